FILE: rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque: command codes, register
// decode and the per-transaction status passed from control to output stage.
// ----------------------------------------------------------------------------
package cdq_pkg;

	typedef enum logic [1:0] {
		CMD_PUSH_REAR  = 2'd0,
		CMD_PUSH_FRONT = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_REAR   = 2'd3
	} cmd_t;

	localparam int CAP_W = 7;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef struct packed {
		logic             is_pop;
		logic             error;
		logic [CAP_W-1:0] count_after;
		logic             empty_after;
		logic             is_full;
	} res_info_t;

endpackage

FILE: rtl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue held in a ring store, with an APB-style capacity register.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    command, data_in
//   output    out        out_valid / out_stall  data_out, error, count_after,
//                                               empty_after, is_full
//   config    in/out     psel/penable/pready    paddr, pwdata, prdata
//
// One transaction is accepted per cycle while in_stall is low; the ring store
// is read at the accepting edge and the result is loaded into the output
// register when the read stage moves on, which waits while the output is held.
// Pointers and count are updated at acceptance, so the next transaction may
// follow at once. Reset empties the deque and sets capacity to 64; no clearing
// pass. When the output register is held and the read stage is full, in_stall rises.
// ----------------------------------------------------------------------------
module circular_deque #(
	parameter int MAX_DEPTH  = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] data_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] data_out,
	output logic               error,
	output logic [6:0]         count_after,
	output logic               empty_after,
	output logic               is_full,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int PW = $clog2(MAX_DEPTH);

	logic                          accept;
	logic                          cfg_we;
	logic [cdq_pkg::CAP_W-1:0]     capacity;
	logic                          ram_we;
	logic                          ram_re;
	logic [PW-1:0]                 ram_addr;
	logic [DATA_WIDTH-1:0]         ram_wdata;
	logic [DATA_WIDTH-1:0]         ram_rdata;
	logic [31:0]                   rd_word;
	cdq_pkg::res_info_t            info;

	logic                          valid_s1;
	cdq_pkg::res_info_t            info_s1;
	logic                          out_valid_q;
	logic [31:0]                   data_q;
	cdq_pkg::res_info_t            info_q;
	logic                          out_blocked;
	logic                          s1_move;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == cdq_pkg::REG_CAPACITY);
	assign prdata = (paddr[2] == cdq_pkg::REG_CAPACITY) ? 32'(capacity) : '0;

	assign out_blocked = out_valid_q && out_stall;
	assign in_stall    = valid_s1 && out_blocked;
	assign accept      = in_valid && !in_stall;
	assign s1_move     = valid_s1 && !out_blocked;

	// values are kept in the low DATA_WIDTH bits, zero extended on the way out
	if (DATA_WIDTH >= 32) begin : g_wide
		assign ram_wdata = DATA_WIDTH'($unsigned(data_in));
		assign rd_word   = ram_rdata[31:0];
	end else begin : g_narrow
		assign ram_wdata = data_in[DATA_WIDTH-1:0];
		assign rd_word   = 32'(ram_rdata);
	end

	cdq_ctrl #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (cdq_pkg::cmd_t'(command)),
		.cfg_we   (cfg_we),
		.cfg_wdata(pwdata[cdq_pkg::CAP_W-1:0]),
		.capacity (capacity),
		.ram_we   (ram_we),
		.ram_re   (ram_re),
		.ram_addr (ram_addr),
		.info     (info)
	);

	cdq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(MAX_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// read data stays put while the read stage waits, as no new read is issued
	always_ff @(posedge clk) begin
		if (s1_move) begin
			data_q <= (info_s1.is_pop && !info_s1.error) ? rd_word : '0;
			info_q <= info_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_out    = $signed(data_q);
	assign error       = info_q.error;
	assign count_after = info_q.count_after;
	assign empty_after = info_q.empty_after;
	assign is_full     = info_q.is_full;

endmodule

FILE: rtl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

FILE: rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Pointer and count keeper of the deque. Decides each transaction at
// acceptance, issues the ring store access and reports the resulting status.
// ----------------------------------------------------------------------------
module cdq_ctrl #(
	parameter int MAX_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  cdq_pkg::cmd_t                command,
	input  logic                         cfg_we,
	input  logic [cdq_pkg::CAP_W-1:0]    cfg_wdata,
	output logic [cdq_pkg::CAP_W-1:0]    capacity,
	output logic                         ram_we,
	output logic                         ram_re,
	output logic [$clog2(MAX_DEPTH)-1:0] ram_addr,
	output cdq_pkg::res_info_t           info
);

	localparam int PW = $clog2(MAX_DEPTH);
	localparam int CW = $clog2(MAX_DEPTH + 1);

	logic [cdq_pkg::CAP_W-1:0] cap_q;
	logic [PW-1:0]             front_q;
	logic [PW-1:0]             rear_q;
	logic [CW-1:0]             count_q;

	logic [CW-1:0] eff_cap;
	logic [CW-1:0] front_inc;
	logic [CW-1:0] rear_inc;
	logic [PW-1:0] front_fwd;
	logic [PW-1:0] front_back;
	logic [PW-1:0] rear_fwd;
	logic [PW-1:0] rear_back;
	logic [PW-1:0] front_d;
	logic [PW-1:0] rear_d;
	logic [CW-1:0] count_d;
	logic          full;
	logic          empty;
	logic          err;

	// zero acts as one, anything above the store depth is clamped
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (32'(cap_q) > 32'(MAX_DEPTH)) begin
			eff_cap = CW'(MAX_DEPTH);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	assign front_inc  = CW'(front_q) + CW'(1);
	assign rear_inc   = CW'(rear_q) + CW'(1);
	assign front_fwd  = (front_inc >= eff_cap) ? '0 : PW'(front_inc);
	assign rear_fwd   = (rear_inc >= eff_cap) ? '0 : PW'(rear_inc);
	assign front_back = (front_q == '0) ? PW'(eff_cap - CW'(1)) : front_q - PW'(1);
	assign rear_back  = (rear_q == '0) ? PW'(eff_cap - CW'(1)) : rear_q - PW'(1);

	assign full  = (count_q >= eff_cap);
	assign empty = (count_q == '0);

	always_comb begin
		front_d  = front_q;
		rear_d   = rear_q;
		count_d  = count_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = rear_q;
		err      = 1'b0;
		case (command)
			cdq_pkg::CMD_PUSH_REAR: begin
				if (full) begin
					err = 1'b1;
				end else begin
					ram_we  = accept;
					rear_d  = rear_fwd;
					count_d = count_q + CW'(1);
				end
			end
			cdq_pkg::CMD_PUSH_FRONT: begin
				ram_addr = front_back;
				if (full) begin
					err = 1'b1;
				end else begin
					ram_we  = accept;
					front_d = front_back;
					count_d = count_q + CW'(1);
				end
			end
			cdq_pkg::CMD_POP_FRONT: begin
				ram_addr = front_q;
				if (empty) begin
					err = 1'b1;
				end else begin
					ram_re  = accept;
					front_d = front_fwd;
					count_d = count_q - CW'(1);
				end
			end
			cdq_pkg::CMD_POP_REAR: begin
				ram_addr = rear_back;
				if (empty) begin
					err = 1'b1;
				end else begin
					ram_re  = accept;
					rear_d  = rear_back;
					count_d = count_q - CW'(1);
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase
	end

	assign info.is_pop      = (command == cdq_pkg::CMD_POP_FRONT) ||
	                          (command == cdq_pkg::CMD_POP_REAR);
	assign info.error       = err;
	assign info.count_after = cdq_pkg::CAP_W'(count_d);
	assign info.empty_after = (count_d == '0);
	assign info.is_full     = (count_d == eff_cap);

	assign capacity = cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= cdq_pkg::CAP_RESET;
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			// a capacity write also empties the deque
			cap_q   <= cfg_wdata;
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			count_q <= count_d;
		end
	end

endmodule

FILE: tb/circular_deque_tb.sv
// ----------------------------------------------------------------------------
// circular_deque_tb
// Self-checking bench for the circular deque. A clocked driver feeds push and
// pop transactions from a pending list, a clocked monitor checks every result
// against an in-bench deque predictor. The run goes through several capacity
// settings, with random gaps and stalls on both channels and two long output
// holds that back the block up into its input.
// ----------------------------------------------------------------------------
module circular_deque_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RING_DEPTH  = 64;
	localparam int RANDOM_OPS  = 138;
	localparam logic [2:0] CAPACITY_ADDR = {cdq_pkg::REG_CAPACITY, 2'b00};

	typedef struct {
		cdq_pkg::cmd_t      cmd;
		logic signed [31:0] value;
	} deque_op_t;

	typedef struct packed {
		logic signed [31:0]        value;
		logic                      refused;
		logic [cdq_pkg::CAP_W-1:0] count;
		logic                      empty;
		logic                      full;
	} deque_result_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [1:0]         command     = cdq_pkg::CMD_PUSH_REAR;
	logic signed [31:0] data_in     = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic signed [31:0] data_out;
	logic               error;
	logic [6:0]         count_after;
	logic               empty_after;
	logic               is_full;
	logic               psel        = 1'b0;
	logic               penable     = 1'b0;
	logic               pwrite      = 1'b0;
	logic [2:0]         paddr       = '0;
	logic [31:0]        pwdata      = '0;
	logic [31:0]        prdata;
	logic               pready;

	circular_deque uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.data_in    (data_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_out   (data_out),
		.error      (error),
		.count_after(count_after),
		.empty_after(empty_after),
		.is_full    (is_full),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #1 clk = ~clk;

	deque_op_t     pending_ops[$];
	deque_result_t expected_results[$];

	// predicted deque contents
	logic [31:0]               ring_mem [RING_DEPTH];
	int unsigned               head_pos    = 0;
	int unsigned               tail_pos    = 0;
	int unsigned               fill_level  = 0;
	logic [cdq_pkg::CAP_W-1:0] cap_setting = cdq_pkg::CAP_RESET;

	int  mismatches     = 0;
	int  items_accepted = 0;
	int  results_seen   = 0;
	int  refused_ops    = 0;
	int  full_hits      = 0;
	int  cycles         = 0;
	int  gap_left       = 0;
	int  stall_left     = 0;
	int  hold_left      = 0;
	bit  in_quiet       = 1'b0;
	bit  out_quiet      = 1'b0;

	function automatic int unsigned usable_depth();
		if (cap_setting == 0)
			return 1;
		if (cap_setting > RING_DEPTH)
			return RING_DEPTH;
		return cap_setting;
	endfunction

	function automatic int unsigned wrap_up(input int unsigned pos, input int unsigned lim);
		return (pos + 1 >= lim) ? 0 : pos + 1;
	endfunction

	function automatic int unsigned wrap_down(input int unsigned pos, input int unsigned lim);
		return (pos == 0 || pos >= lim) ? lim - 1 : pos - 1;
	endfunction

	function automatic int draw_gap();
		int r;
		if (in_quiet)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	task automatic predict_op(input cdq_pkg::cmd_t c, input logic signed [31:0] v);
		deque_result_t r;
		int unsigned   lim;
		lim = usable_depth();
		r = '0;
		if (c == cdq_pkg::CMD_PUSH_REAR || c == cdq_pkg::CMD_PUSH_FRONT) begin
			if (fill_level >= lim) begin
				r.refused = 1'b1;
			end else if (c == cdq_pkg::CMD_PUSH_REAR) begin
				ring_mem[tail_pos] = v;
				tail_pos = wrap_up(tail_pos, lim);
				fill_level++;
			end else begin
				head_pos = wrap_down(head_pos, lim);
				ring_mem[head_pos] = v;
				fill_level++;
			end
		end else begin
			if (fill_level == 0) begin
				r.refused = 1'b1;
			end else if (c == cdq_pkg::CMD_POP_FRONT) begin
				r.value = ring_mem[head_pos];
				head_pos = wrap_up(head_pos, lim);
				fill_level--;
			end else begin
				// rear pointer steps back before the read
				tail_pos = wrap_down(tail_pos, lim);
				r.value = ring_mem[tail_pos];
				fill_level--;
			end
		end
		r.count = cdq_pkg::CAP_W'(fill_level);
		r.empty = (fill_level == 0);
		r.full  = (fill_level == lim);
		if (r.refused)
			refused_ops++;
		if (r.full)
			full_hits++;
		expected_results.push_back(r);
	endtask

	task automatic add_op(input cdq_pkg::cmd_t c, input logic signed [31:0] v);
		deque_op_t op;
		op.cmd   = c;
		op.value = v;
		pending_ops.push_back(op);
	endtask

	// driver: one transaction in flight, held while stalled
	always @(posedge clk) begin : driver
		deque_op_t op;
		if (arst_n && !(in_valid && in_stall)) begin
			if (in_valid) begin
				predict_op(cdq_pkg::cmd_t'(command), data_in);
				items_accepted++;
				gap_left = draw_gap();
			end else if (gap_left > 0) begin
				gap_left--;
			end
			if (gap_left == 0 && pending_ops.size() > 0) begin
				op = pending_ops.pop_front();
				in_valid <= 1'b1;
				command  <= op.cmd;
				data_in  <= op.value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks results and drives the output stall
	always @(posedge clk) begin : monitor
		deque_result_t exp_r;
		deque_result_t act_r;
		int            r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				act_r.value   = data_out;
				act_r.refused = error;
				act_r.count   = count_after;
				act_r.empty   = empty_after;
				act_r.full    = is_full;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: data %h err %b count %0d empty %b full %b",
							act_r.value, act_r.refused, act_r.count, act_r.empty, act_r.full);
				end else begin
					exp_r = expected_results.pop_front();
					if (act_r !== exp_r) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch on result %0d: expected data %h err %b count %0d %s",
								results_seen, exp_r.value, exp_r.refused, exp_r.count,
								$sformatf("empty %b full %b", exp_r.empty, exp_r.full));
							$display("  got data %h err %b count %0d empty %b full %b",
								act_r.value, act_r.refused, act_r.count, act_r.empty,
								act_r.full);
						end
					end
				end
				results_seen++;
				// long hold so the block backs up into its input
				if (results_seen == 400 || results_seen == 1100)
					hold_left = 200;
			end
			if (hold_left == 0 && stall_left == 0 && !out_quiet) begin
				r = $urandom_range(99);
				if (r >= 97)
					stall_left = $urandom_range(40, 10);
				else if (r >= 75)
					stall_left = $urandom_range(3, 1);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int                 cap_plan [12];
		logic [31:0]        readback;
		logic signed [31:0] v;
		int                 left;
		int                 run;
		int                 push_pct;
		cdq_pkg::cmd_t      c;

		cap_plan = '{64, 1, 0, 2, 3, 100, 127, 64, 5, 17, 33, 64};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 12; ph++) begin
			// capacity write, then read back; the first setting is the reset one
			@(posedge clk);
			if (ph > 0) begin
				psel    <= 1'b1;
				penable <= 1'b0;
				pwrite  <= 1'b1;
				paddr   <= CAPACITY_ADDR;
				pwdata  <= 32'(cap_plan[ph]);
				@(posedge clk);
				penable <= 1'b1;
				@(posedge clk);
				while (!pready)
					@(posedge clk);
				cap_setting = cdq_pkg::CAP_W'(cap_plan[ph]);
				head_pos    = 0;
				tail_pos    = 0;
				fill_level  = 0;
			end
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			paddr   <= CAPACITY_ADDR;
			@(posedge clk);
			penable <= 1'b1;
			@(negedge clk);
			readback = prdata;
			@(posedge clk);
			psel    <= 1'b0;
			penable <= 1'b0;
			if (readback !== 32'(cap_setting)) begin
				mismatches++;
				if (mismatches <= 10)
					$display("capacity read back %h, expected %h", readback, cap_setting);
			end

			in_quiet  = (ph % 3 == 1);
			out_quiet = (ph % 4 == 2);

			if (ph == 0) begin
				// pops on empty, both extremes of data, front wrap below index zero
				add_op(cdq_pkg::CMD_POP_FRONT,  32'h1234_5678);
				add_op(cdq_pkg::CMD_POP_REAR,   32'hFFFF_FFFF);
				add_op(cdq_pkg::CMD_PUSH_REAR,  32'h7FFF_FFFF);
				add_op(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
				add_op(cdq_pkg::CMD_PUSH_REAR,  32'h0000_0000);
				add_op(cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
				add_op(cdq_pkg::CMD_POP_REAR,   32'h0);
				add_op(cdq_pkg::CMD_POP_FRONT,  32'h0);
				add_op(cdq_pkg::CMD_POP_FRONT,  32'h0);
				add_op(cdq_pkg::CMD_POP_REAR,   32'h0);
				add_op(cdq_pkg::CMD_POP_REAR,   32'h0);
				add_op(cdq_pkg::CMD_PUSH_FRONT, 32'h5A5A_5A5A);
				add_op(cdq_pkg::CMD_POP_REAR,   32'h0);
			end else if (ph == 1) begin
				// single entry: pushes on full both ways and a rear pop on empty
				add_op(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0001);
				add_op(cdq_pkg::CMD_PUSH_REAR,  32'h0000_0002);
				add_op(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0003);
				add_op(cdq_pkg::CMD_POP_FRONT,  32'h0);
				add_op(cdq_pkg::CMD_POP_REAR,   32'h0);
				add_op(cdq_pkg::CMD_PUSH_REAR,  32'hA5A5_A5A5);
				add_op(cdq_pkg::CMD_POP_REAR,   32'h0);
			end

			// random runs with a push bias, some long enough to fill the ring
			left = RANDOM_OPS;
			while (left > 0) begin
				case ($urandom_range(3))
					0: begin push_pct = 25; run = $urandom_range(40, 8); end
					1: begin push_pct = 50; run = $urandom_range(40, 8); end
					2: begin push_pct = 80; run = $urandom_range(40, 8); end
					default: begin push_pct = 95; run = usable_depth() + 4; end
				endcase
				while (run > 0 && left > 0) begin
					if ($urandom_range(99) < push_pct)
						c = $urandom_range(1) ? cdq_pkg::CMD_PUSH_REAR
						                      : cdq_pkg::CMD_PUSH_FRONT;
					else
						c = $urandom_range(1) ? cdq_pkg::CMD_POP_FRONT
						                      : cdq_pkg::CMD_POP_REAR;
					case ($urandom_range(15))
						0: v = 32'h7FFF_FFFF;
						1: v = 32'h8000_0000;
						2: v = 32'hFFFF_FFFF;
						3: v = 32'h0000_0000;
						default: v = $urandom;
					endcase
					add_op(c, v);
					run--;
					left--;
				end
			end

			while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
				@(posedge clk);
			repeat (4) @(posedge clk);
		end

		if (expected_results.size() != 0)
			mismatches++;
		$display("%0d transactions over 12 capacity settings, %0d results checked",
			items_accepted, results_seen);
		$display("%0d refused on full or empty, %0d left the deque full, %0d mismatches",
			refused_ops, full_hits, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
